@@ rtl/core/grcs_pkg.sv @@
// ----------------------------------------------------------------------------
// grcs_pkg: shared types and constants of the grid ray cell stepper
// Transaction payload structs, configuration register indexes and fixed widths.
// ----------------------------------------------------------------------------
package grcs_pkg;

	// Direction cosine and sine carry 14 fraction bits; positions are aligned
	// to the same scale before they are stepped.
	localparam int DIR_FRAC_BITS = 14;

	// Configuration registers are nine bits wide.
	localparam int CFG_W        = 9;
	localparam int CFG_IDX_W    = 2;
	localparam int CELL_OUT_W   = 16;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

	localparam logic [CFG_W-1:0] GRID_DIM_RESET = 9'd100;

	typedef struct packed {
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] dir_cos;
		logic signed [15:0] dir_sin;
		logic [6:0]         num_steps;
	} in_item_t;

	typedef struct packed {
		logic [CELL_OUT_W-1:0] cell_index;
		logic                  last_cell;
	} out_item_t;

endpackage

@@ rtl/core/grid_ray_cell_stepper_unit.sv @@
// ----------------------------------------------------------------------------
// grid_ray_cell_stepper_unit: fixed-step ray marching over an occupancy grid
// Steps one ray through the grid and emits each distinct in-grid cell it hits.
// ----------------------------------------------------------------------------
// A cell is held back until a different in-grid cell or the end of its ray
// follows; the final cell is released from the flush state with its last flag
// set. Step counts above MAX_STEPS are clamped to MAX_STEPS.
// A new ray is taken only while idle, after the previous ray is flushed; the
// position accumulators advance one sample per cycle; an output stall freezes all.
// Reset: arst_n clears all control state and sets both grid sizes to 100.
module grid_ray_cell_stepper_unit #(
	parameter int MAX_DIM       = 256,
	parameter int MAX_STEPS     = 64,
	parameter int POS_FRAC_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  grcs_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output grcs_pkg::out_item_t          out_data,
	input  logic                         cfg_we,
	input  logic [grcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [grcs_pkg::CFG_W-1:0]   cfg_wdata
);
	import grcs_pkg::*;

	// Shift that brings the start point onto the direction's fraction scale.
	localparam int ALIGN   = DIR_FRAC_BITS - POS_FRAC_BITS;
	// Bits for the step counter, which must hold MAX_STEPS itself.
	localparam int STEP_W  = $clog2(MAX_STEPS + 1);
	// The accumulator holds |start| <= 2^(15+ALIGN) plus up to MAX_STEPS
	// direction steps of at most 2^15 each, with a sign bit to spare.
	localparam int ACC_W   = 17 + ((ALIGN > STEP_W) ? ALIGN : STEP_W);
	localparam int FLOOR_W = ACC_W - DIR_FRAC_BITS;
	// Grid size (can equal MAX_DIM) and grid index (below MAX_DIM) widths.
	localparam int DIM_W   = $clog2(MAX_DIM + 1);
	localparam int IDX_W   = $clog2(MAX_DIM);
	localparam int CW      = ((FLOOR_W > DIM_W) ? FLOOR_W : DIM_W) + 2;
	localparam int PROD_W  = IDX_W + DIM_W;
	localparam int CELL_W  = 2 * IDX_W;

	// The sequencer: idle, stepping the ray, and a final flush state that releases
	// the held-back cell, if any, with its last flag set.
	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [CFG_W-1:0] grid_w_q;
	logic [CFG_W-1:0] grid_h_q;

	// Stepping state: the accumulator pair and the steps still to go.
	logic signed [ACC_W-1:0] px_q;
	logic signed [ACC_W-1:0] py_q;
	logic signed [15:0]      dc_q;
	logic signed [15:0]      ds_q;
	logic [STEP_W-1:0]       steps_left_q;

	// First stage: grid coordinates of one sample and whether it lies inside.
	logic             v_s1;
	logic             fin_s1;
	logic             inside_s1;
	logic [IDX_W-1:0] col_s1;
	logic [IDX_W-1:0] row_s1;

	// The cell held back until the next distinct cell or the end of the ray.
	logic              pend_vld_q;
	logic              have_prev_q;
	logic [CELL_W-1:0] pend_q;

	// Output register.
	logic      out_vld_q;
	out_item_t out_q;

	// Clamped grid sizes and their halves.
	logic [DIM_W-1:0] w_eff;
	logic [DIM_W-1:0] h_eff;

	// Combinational datapath.
	logic signed [FLOOR_W-1:0] fx;
	logic signed [FLOOR_W-1:0] fy;
	logic signed [CW-1:0]      col_c;
	logic signed [CW-1:0]      row_c;
	logic signed [CW-1:0]      w_s;
	logic signed [CW-1:0]      h_s;
	logic signed [CW-1:0]      hw_s;
	logic signed [CW-1:0]      hh_s;
	logic                      inside_c;
	logic [PROD_W-1:0]         prod_c;
	logic [CELL_W-1:0]         cell_c;
	logic                      new_cell;
	logic                      adv;
	logic                      push;
	out_item_t                 push_data;
	logic [STEP_W-1:0]         steps_init;
	logic                      in_acc;

	// A zero register acts as one, anything above MAX_DIM as MAX_DIM.
	always_comb begin
		if (grid_w_q == '0) begin
			w_eff = DIM_W'(1);
		end else if (grid_w_q > CFG_W'(MAX_DIM)) begin
			w_eff = DIM_W'(MAX_DIM);
		end else begin
			w_eff = grid_w_q[DIM_W-1:0];
		end
		if (grid_h_q == '0) begin
			h_eff = DIM_W'(1);
		end else if (grid_h_q > CFG_W'(MAX_DIM)) begin
			h_eff = DIM_W'(MAX_DIM);
		end else begin
			h_eff = grid_h_q[DIM_W-1:0];
		end
	end

	assign w_s  = CW'(w_eff);
	assign h_s  = CW'(h_eff);
	assign hw_s = CW'(w_eff >> 1);
	assign hh_s = CW'(h_eff >> 1);

	// Dropping the fraction bits of a two's complement value is a floor.
	assign fx    = px_q[ACC_W-1:DIR_FRAC_BITS];
	assign fy    = py_q[ACC_W-1:DIR_FRAC_BITS];
	assign col_c = CW'(fx) + hw_s;
	assign row_c = hh_s - CW'(fy);
	assign inside_c = (col_c >= 0) && (col_c < w_s) && (row_c >= 0) && (row_c < h_s);

	// Linear cell index of the first-stage sample.
	assign prod_c   = PROD_W'(row_s1) * PROD_W'(w_eff);
	assign cell_c   = CELL_W'(prod_c + PROD_W'(col_s1));
	assign new_cell = v_s1 && inside_s1 && !(have_prev_q && (cell_c == pend_q));

	// Everything moves only while the output register can take a new item.
	assign adv = !(out_vld_q && !out_ready);

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	assign steps_init = (in_data.num_steps > 7'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
		: STEP_W'(in_data.num_steps);

	// A held-back cell leaves when a newer distinct cell replaces it, or at the
	// end of the ray, where it is the final one.
	always_comb begin
		push                 = 1'b0;
		push_data.cell_index = CELL_OUT_W'(pend_q);
		push_data.last_cell  = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				push = new_cell && pend_vld_q;
			end
			ST_FLUSH: begin
				push                = pend_vld_q;
				push_data.last_cell = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_w_q <= GRID_DIM_RESET;
			grid_h_q <= GRID_DIM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_GRID_WIDTH) begin
				grid_w_q <= cfg_wdata;
			end else if (cfg_index == REG_GRID_HEIGHT) begin
				grid_h_q <= cfg_wdata;
			end
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			steps_left_q <= '0;
			v_s1         <= 1'b0;
			fin_s1       <= 1'b0;
			pend_vld_q   <= 1'b0;
			have_prev_q  <= 1'b0;
			out_vld_q    <= 1'b0;
		end else begin
			if (adv) begin
				out_vld_q <= push;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						steps_left_q <= steps_init;
						v_s1         <= 1'b0;
						pend_vld_q   <= 1'b0;
						have_prev_q  <= 1'b0;
						state_q      <= (steps_init == '0) ? ST_FLUSH : ST_RUN;
					end
				end
				ST_RUN: begin
					if (adv) begin
						if (steps_left_q != '0) begin
							v_s1         <= 1'b1;
							fin_s1       <= (steps_left_q == STEP_W'(1));
							steps_left_q <= steps_left_q - STEP_W'(1);
						end else begin
							v_s1 <= 1'b0;
						end
						if (new_cell) begin
							pend_vld_q  <= 1'b1;
							have_prev_q <= 1'b1;
						end
						if (v_s1 && fin_s1) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (adv) begin
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; no reset needed.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_q <= ACC_W'(in_data.start_x) <<< ALIGN;
			py_q <= ACC_W'(in_data.start_y) <<< ALIGN;
			dc_q <= in_data.dir_cos;
			ds_q <= in_data.dir_sin;
		end else if ((state_q == ST_RUN) && adv && (steps_left_q != '0)) begin
			// Sample the current point, then advance by one direction step.
			col_s1    <= col_c[IDX_W-1:0];
			row_s1    <= row_c[IDX_W-1:0];
			inside_s1 <= inside_c;
			px_q      <= px_q + ACC_W'(dc_q);
			py_q      <= py_q + ACC_W'(ds_q);
		end
		if ((state_q == ST_RUN) && adv && new_cell) begin
			pend_q <= cell_c;
		end
		if (adv && push) begin
			out_q <= push_data;
		end
	end

`ifndef SYNTHESIS
	// A new ray is never taken while a sample is still in the first stage.
	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !v_s1)
		else $error("ray accepted with a sample still in flight");

	// The final flush starts only after every step has been issued.
	a_flush_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH) |-> (steps_left_q == '0))
		else $error("flush entered with steps left");

	// A held-back cell always implies a previous cell for the comparison.
	a_pend_prev: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> have_prev_q)
		else $error("pending cell without previous cell");

	// In the cycle after a ray transaction the block is busy.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready right after accepting a ray");
`endif

endmodule
